// ===== hw/rtl/utf8e_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the utf-8 code point encoder
package utf8e_pkg;

  localparam int CP_W        = 31;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  // sequence lengths in bytes
  localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4 = 3'd4;
  localparam logic [LEN_W-1:0] LEN_5 = 3'd5;
  localparam logic [LEN_W-1:0] LEN_6 = 3'd6;

  // lead byte prefixes and continuation byte fields
  localparam logic [BYTE_W-1:0] LEAD_2    = 8'b11000000;
  localparam logic [BYTE_W-1:0] LEAD_3    = 8'b11100000;
  localparam logic [BYTE_W-1:0] LEAD_4    = 8'b11110000;
  localparam logic [BYTE_W-1:0] LEAD_5    = 8'b11111000;
  localparam logic [BYTE_W-1:0] LEAD_6    = 8'b11111100;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'b10000000;
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'b00111111;

  // one classified code point waiting for serialisation
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
  } item_t;

  function automatic logic [LEN_W-1:0] seq_len(input logic [CP_W-1:0] cp);
    logic [LEN_W-1:0] n;
    if (cp <= 31'h7F)           n = LEN_1;
    else if (cp <= 31'h7FF)     n = LEN_2;
    else if (cp <= 31'hFFFF)    n = LEN_3;
    else if (cp <= 31'h1FFFFF)  n = LEN_4;
    else if (cp <= 31'h3FFFFFF) n = LEN_5;
    else                        n = LEN_6;
    return n;
  endfunction

endpackage

// ===== hw/rtl/utf8_code_point_encoder.sv =====
`timescale 1ns / 1ps
// top level of the utf-8 code point encoder
//
// input side is a queue: drive in_code_point and raise push; the transaction
// is taken at a clock edge where push is high and full is low. result side is
// a queue too: while empty is low, out_byte and out_last_byte hold the oldest
// byte, taken at a clock edge where pop is high.
// each code point gives 1 to 6 bytes, lead byte first; out_last_byte marks the
// final byte of the sequence.
// the lead byte passes through the queue, the serialiser and the output register
// to the result ports. the serialiser gives one byte per cycle while the output
// register is empty or popped, and loads the next code point with the last byte.
// a short queue between the classifying front end and the serialiser keeps
// input taken while a byte waits on the output register.
// if the receiver stalls, the output register holds its byte, the serialiser
// and the queue fill, and full rises. synchronous reset empties the queue and
// the output register; no clearing pass follows.
module utf8_code_point_encoder #(
  parameter int QUEUE_DEPTH = utf8e_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [utf8e_pkg::CP_W-1:0]    in_code_point,
  output logic                          empty,
  input  logic                          pop,
  output logic [utf8e_pkg::BYTE_W-1:0]  out_byte,
  output logic                          out_last_byte
);
  import utf8e_pkg::*;

  logic  q_full, q_push, q_valid, q_pop;
  item_t wr_item, rd_item;

  utf8e_front u_front (
    .push          (push),
    .in_code_point (in_code_point),
    .full          (full),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (wr_item)
  );

  utf8e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (wr_item),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_item (rd_item),
    .q_valid (q_valid)
  );

  utf8e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (rd_item),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

// ===== hw/rtl/utf8e_front.sv =====
`timescale 1ns / 1ps
// front end: accepts code points and tags each with its sequence length
module utf8e_front (
  input  logic                   push,
  input  logic [utf8e_pkg::CP_W-1:0] in_code_point,
  output logic                   full,
  input  logic                   q_full,
  output logic                   q_push,
  output utf8e_pkg::item_t       q_item
);
  import utf8e_pkg::*;

  assign full        = q_full;
  assign q_push      = push & ~q_full;
  assign q_item.cp   = in_code_point;
  assign q_item.len  = seq_len(in_code_point);

endmodule

// ===== hw/rtl/utf8e_queue.sv =====
`timescale 1ns / 1ps
// short queue of classified items between front and back
module utf8e_queue #(
  parameter int DEPTH = utf8e_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  utf8e_pkg::item_t  wr_item,
  output logic              q_full,
  input  logic              rd_en,
  output utf8e_pkg::item_t  rd_item,
  output logic              q_valid
);
  import utf8e_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign rd_item = mem[rd_ptr_r];
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/utf8e_back.sv =====
`timescale 1ns / 1ps
// back end: turns items into output register bytes, one per cycle unless stalled
module utf8e_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  utf8e_pkg::item_t               q_item,
  output logic                           q_pop,
  input  logic                           pop,
  output logic                           empty,
  output logic [utf8e_pkg::BYTE_W-1:0]   out_byte,
  output logic                           out_last_byte
);
  import utf8e_pkg::*;

  logic [CP_W-1:0]   cp_r, cp_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              first_r, first_nxt;
  logic              busy_r, busy_nxt;
  logic              ovld_r, ovld_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              emit, load;
  logic [BYTE_W-1:0] cur_byte;
  logic [5:0]        cont_bits;

  assign emit  = busy_r & (~ovld_r | pop);
  assign load  = q_valid & (~busy_r | (emit & (rem_r == '0)));
  assign q_pop = load;

  // six payload bits of the continuation byte at the remaining position
  always_comb begin
    case (rem_r)
      3'd0:    cont_bits = cp_r[5:0];
      3'd1:    cont_bits = cp_r[11:6];
      3'd2:    cont_bits = cp_r[17:12];
      3'd3:    cont_bits = cp_r[23:18];
      3'd4:    cont_bits = cp_r[29:24];
      default: cont_bits = {5'b0, cp_r[30]};
    endcase
  end

  always_comb begin
    if (first_r) begin
      case (len_r)
        LEN_1:   cur_byte = {1'b0, cp_r[6:0]};
        LEN_2:   cur_byte = LEAD_2 | {3'b0, cp_r[10:6]};
        LEN_3:   cur_byte = LEAD_3 | {4'b0, cp_r[15:12]};
        LEN_4:   cur_byte = LEAD_4 | {5'b0, cp_r[20:18]};
        LEN_5:   cur_byte = LEAD_5 | {6'b0, cp_r[25:24]};
        default: cur_byte = LEAD_6 | {7'b0, cp_r[30]};
      endcase
    end else begin
      cur_byte = CONT_TAG | ({2'b0, cont_bits} & CONT_MASK);
    end
  end

  always_comb begin
    cp_nxt    = cp_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    first_nxt = first_r;
    busy_nxt  = busy_r;
    ovld_nxt  = ovld_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (ovld_r && pop) begin
      ovld_nxt = 1'b0;
    end
    if (emit) begin
      ovld_nxt  = 1'b1;
      byte_nxt  = cur_byte;
      last_nxt  = (rem_r == '0);
      first_nxt = 1'b0;
      rem_nxt   = rem_r - 1'b1;
      if (rem_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt  = 1'b1;
      cp_nxt    = q_item.cp;
      len_nxt   = q_item.len;
      rem_nxt   = q_item.len - 1'b1;
      first_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r    <= cp_nxt;
    len_r   <= len_nxt;
    rem_r   <= rem_nxt;
    first_r <= first_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
  end

  assign empty         = ~ovld_r;
  assign out_byte      = byte_r;
  assign out_last_byte = last_r;

  // lead byte always comes with the full count still to go
  a_lead_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && first_r) |-> (rem_r == len_r - 1'b1))
    else $error("lead byte with wrong remaining count");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (len_r >= LEN_1 && len_r <= LEN_6 && rem_r < len_r))
    else $error("sequence length out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (ovld_r && (last_r == $past(rem_r == '0))))
    else $error("last-byte flag does not match sequence position");

endmodule
